### hdl/alpha_color_bleed_3x3_assert.svh
// Assertion macros used by the port checker of the color bleed block.
`ifndef ALPHA_COLOR_BLEED_3X3_ASSERT_SVH
`define ALPHA_COLOR_BLEED_3X3_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/acb_pkg.sv
// Package: constants, types and register codes of the color bleed block.
package acb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CHAN_W = 8;
  localparam int PIX_W  = 32;
  localparam int DIM_W  = 11;
  localparam int CROP_W = 10;
  localparam int NCH    = 3;
  localparam int NWIN   = 9;
  localparam int CENTER = 4;
  localparam int SUM_W  = 11;
  localparam int CNT_W  = 4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CROP_LEFT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CROP_TOP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CROP_RIGHT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CROP_BOTTOM  = 3'd5;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [CROP_W-1:0] RST_CROP_LEFT    = 10'd0;
  localparam logic [CROP_W-1:0] RST_CROP_TOP     = 10'd0;
  localparam logic [CROP_W-1:0] RST_CROP_RIGHT   = 10'd1023;
  localparam logic [CROP_W-1:0] RST_CROP_BOTTOM  = 10'd1023;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [CROP_W-1:0] crop_left;
    logic [CROP_W-1:0] crop_top;
    logic [CROP_W-1:0] crop_right;
    logic [CROP_W-1:0] crop_bottom;
  } acb_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } acb_state_t;

endpackage

### hdl/acb_if.sv
// Stream interfaces: pixel input channel and result output channel.
interface acb_pix_if;
  import acb_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, command, blue, green, red, alpha, input ready);
  modport sink   (input valid, command, blue, green, red, alpha, output ready);
endinterface

interface acb_res_if;
  import acb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_alpha;
  logic              frame_last;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_last,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, frame_last,
                  output ready);
endinterface

### hdl/acb_regs.sv
// APB configuration registers of the color bleed block.
module acb_regs import acb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output acb_cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.crop_left    <= RST_CROP_LEFT;
      cfg.crop_top     <= RST_CROP_TOP;
      cfg.crop_right   <= RST_CROP_RIGHT;
      cfg.crop_bottom  <= RST_CROP_BOTTOM;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[DIM_W-1:0];
        REG_CROP_LEFT:    cfg.crop_left    <= pwdata[CROP_W-1:0];
        REG_CROP_TOP:     cfg.crop_top     <= pwdata[CROP_W-1:0];
        REG_CROP_RIGHT:   cfg.crop_right   <= pwdata[CROP_W-1:0];
        REG_CROP_BOTTOM:  cfg.crop_bottom  <= pwdata[CROP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg.image_height);
      REG_CROP_LEFT:    prdata = APB_DATA_W'(cfg.crop_left);
      REG_CROP_TOP:     prdata = APB_DATA_W'(cfg.crop_top);
      REG_CROP_RIGHT:   prdata = APB_DATA_W'(cfg.crop_right);
      REG_CROP_BOTTOM:  prdata = APB_DATA_W'(cfg.crop_bottom);
      default:          prdata = '0;
    endcase
  end

endmodule

### hdl/acb_div.sv
// Iterative divider: three channel sums by a shared neighbor count, one bit a cycle.
module acb_div import acb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NCH-1:0][SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         done,
  output logic [NCH-1:0][CHAN_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0]              steps;
  logic [CNT_W-1:0]               div_q;
  logic [NCH-1:0][CNT_W-1:0]      rem;
  logic [NCH-1:0][SUM_W-1:0]      shreg;
  logic [NCH-1:0][CNT_W-1:0]      rem_next;
  logic [NCH-1:0][SUM_W-1:0]      shreg_next;

  // One restoring step per channel: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           fits;
    for (int c = 0; c < NCH; c++) begin
      trial = {rem[c], shreg[c][SUM_W-1]};
      diff  = trial - {1'b0, div_q};
      fits  = trial >= {1'b0, div_q};
      rem_next[c]   = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      shreg_next[c] = {shreg[c][SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (start) begin
        steps <= STEP_W'(SUM_W);
      end else if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_q <= divisor;
      rem   <= '0;
      shreg <= dividend;
    end else if (steps != '0) begin
      rem   <= rem_next;
      shreg <= shreg_next;
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      quotient[c] = shreg[c][CHAN_W-1:0];
    end
  end

endmodule

### hdl/alpha_color_bleed_3x3.sv
// Top level: streaming 3x3 color bleed of transparent BGRA pixels.
//
//   channel  | kind          | payload
//   ---------+---------------+-------------------------------------------------
//   pixels   | valid/ready   | command, blue, green, red, alpha
//   results  | valid/ready   | out_blue, out_green, out_red, out_alpha, frame_last
//   apb      | APB, 32 bit   | image size and crop rectangle, byte address 4*i
//
// One item at a time. A pixel that yields no result goes through line store read,
// write back with window shift and position compare; a passed-through result
// also goes through the sum and output states; an averaged one also waits for the
// 11-step divider. A flush with nothing pending is taken and dropped.
// Reset clears counters, window and control; the line stores need no clearing.
// A stalled results channel holds the block in its output state while the
// previous result waits in the output register.
module alpha_color_bleed_3x3 import acb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  acb_pix_if.sink               pixels,
  acb_res_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Widths: XW holds any size, position or crop bound with room for +1.
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int MW = (WW > HW) ? WW : HW;
  localparam int XW = ((MW > DIM_W) ? MW : DIM_W) + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = 2 * XW;

  acb_cfg_t cfg;

  acb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective frame size: zero acts as one, oversize clamps to MAX_WIDTH and MAX_HEIGHT.
  logic [XW-1:0] width_ext, height_ext, w_eff, h_eff;

  always_comb begin
    width_ext  = XW'(cfg.image_width);
    height_ext = XW'(cfg.image_height);
    if (width_ext == '0) begin
      w_eff = XW'(1);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (height_ext == '0) begin
      h_eff = XW'(1);
    end else if (height_ext > XW'(MAX_HEIGHT)) begin
      h_eff = XW'(MAX_HEIGHT);
    end else begin
      h_eff = height_ext;
    end
  end

  // Control and position state.
  acb_state_t    state, state_next;
  logic [CW-1:0] in_column, out_column;
  logic [XW-1:0] in_row, out_row;

  // Line stores: upper holds the row two back, middle the row one back.
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_q, middle_q;

  // Item in flight.
  logic [PIX_W-1:0] pix_hold;
  logic [PIX_W-1:0] win [NWIN];
  logic [PW-1:0]    in_prod, out_prod, in_idx;
  logic [PW:0]      out_lim;
  logic [NWIN-1:0]  nb_mask;
  logic             pass_c;
  logic             last_flag;
  logic [PIX_W-1:0] res_pix;

  // Output register.
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_last;

  // Handshake terms.
  logic in_acc, drop_flush, out_free, out_load, rd_en, wr_en;

  assign pixels.ready = (state == ST_IDLE);
  assign in_acc       = pixels.valid && pixels.ready;
  // A flush with no frame under way carries nothing: take it and drop it.
  assign drop_flush   = (pixels.command == CMD_FLUSH) && (in_row == '0) &&
                        (in_column == '0) && (out_row == '0) && (out_column == '0);
  assign out_free     = !out_valid || results.ready;
  assign rd_en        = in_acc && !drop_flush;
  assign wr_en        = (state == ST_READ);
  assign out_load     = (state == ST_OUT) && out_free;

  // Read both stores at the input column, write back in the following cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q  <= upper_mem[in_column];
      middle_q <= middle_mem[in_column];
    end
    if (wr_en) begin
      upper_mem[in_column]  <= middle_q;
      middle_mem[in_column] <= pix_hold;
    end
  end

  // Window decode at the output position (window already shifted in ST_READ).
  logic [XW-1:0]   ocol_x;
  logic [XW-1:0]   cl_x, ct_x, cr_x, cb_x;
  logic [2:0]      row_ok, col_ok;
  logic            outside, inverted;
  logic [NWIN-1:0] mask_c;
  logic            emit;

  always_comb begin
    ocol_x = XW'(out_column);
    cl_x   = XW'(cfg.crop_left);
    ct_x   = XW'(cfg.crop_top);
    cr_x   = XW'(cfg.crop_right);
    cb_x   = XW'(cfg.crop_bottom);

    // Neighbor rows and columns that fall inside the image.
    row_ok[0] = (out_row != '0) && (out_row <= h_eff);
    row_ok[1] = (out_row < h_eff);
    row_ok[2] = ((out_row + XW'(1)) < h_eff);
    col_ok[0] = (ocol_x != '0) && (ocol_x <= w_eff);
    col_ok[1] = (ocol_x < w_eff);
    col_ok[2] = ((ocol_x + XW'(1)) < w_eff);

    // Grown crop window, clamped to the image, written without the clamps.
    outside  = ((ocol_x + XW'(1)) < cl_x) || (ocol_x > (cr_x + XW'(1))) ||
               (ocol_x >= w_eff) ||
               ((out_row + XW'(1)) < ct_x) || (out_row > (cb_x + XW'(1))) ||
               (out_row >= h_eff);
    inverted = (cfg.crop_right < cfg.crop_left) || (cfg.crop_bottom < cfg.crop_top);

    for (int k = 0; k < NWIN; k++) begin
      mask_c[k] = (k != CENTER) && row_ok[k / 3] && col_ok[k % 3] &&
                  (win[k][PIX_W-1 -: CHAN_W] != '0);
    end

    emit = ({1'b0, in_idx} >= out_lim);
  end

  // Neighbor sums and count feed the divider directly.
  logic [NCH-1:0][SUM_W-1:0]  sums;
  logic [CNT_W-1:0]           nb_count;
  logic                       div_start, div_done;
  logic [NCH-1:0][CHAN_W-1:0] quot;

  always_comb begin
    sums = '0;
    for (int k = 0; k < NWIN; k++) begin
      for (int c = 0; c < NCH; c++) begin
        if (nb_mask[k]) begin
          sums[c] = sums[c] + SUM_W'(win[k][c*CHAN_W +: CHAN_W]);
        end
      end
    end
    nb_count = CNT_W'($countones(nb_mask));
  end

  assign div_start = (state == ST_SUM) && !pass_c && (nb_count != '0);

  acb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums),
    .divisor  (nb_count),
    .done     (div_done),
    .quotient (quot)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (rd_en) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = emit ? ST_SUM : ST_IDLE;
      ST_SUM:   state_next = div_start ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Position counters and window.
  logic [XW-1:0] in_col_inc, out_col_inc;

  assign in_col_inc  = XW'(in_column) + XW'(1);
  assign out_col_inc = XW'(out_column) + XW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      for (int k = 0; k < NWIN; k++) begin
        win[k] <= '0;
      end
    end else begin
      if (state == ST_READ) begin
        // Shift the window left and bring in the new column.
        for (int r = 0; r < 3; r++) begin
          win[r*3]     <= win[r*3 + 1];
          win[r*3 + 1] <= win[r*3 + 2];
        end
        win[2] <= upper_q;
        win[5] <= middle_q;
        win[8] <= pix_hold;
        if (in_col_inc >= w_eff) begin
          in_column <= '0;
          if (in_row != '1) begin
            in_row <= in_row + XW'(1);
          end
        end else begin
          in_column <= in_col_inc[CW-1:0];
        end
      end
      if (out_load) begin
        if (last_flag) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else if (out_col_inc >= w_eff) begin
          out_column <= '0;
          out_row    <= out_row + XW'(1);
        end else begin
          out_column <= out_col_inc[CW-1:0];
        end
      end
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pix_hold <= (pixels.command == CMD_FLUSH) ? '0 :
                  {pixels.alpha, pixels.red, pixels.green, pixels.blue};
      in_prod  <= {{XW{1'b0}}, in_row} * {{XW{1'b0}}, w_eff};
      out_prod <= {{XW{1'b0}}, out_row} * {{XW{1'b0}}, w_eff};
    end
    if (state == ST_READ) begin
      // Raster indices from the positions before this item advances them.
      in_idx  <= in_prod + PW'(in_column);
      out_lim <= {1'b0, out_prod} + (PW + 1)'(out_column) + (PW + 1)'(w_eff) +
                 (PW + 1)'(1);
    end
    if (state == ST_CHECK) begin
      nb_mask   <= mask_c;
      pass_c    <= (win[CENTER][PIX_W-1 -: CHAN_W] != '0) || inverted || outside;
      last_flag <= ((out_row + XW'(1)) >= h_eff) && (out_col_inc >= w_eff);
    end
    if (state == ST_SUM && !div_start) begin
      res_pix <= win[CENTER];
    end
    if (state == ST_DIV && div_done) begin
      // Alpha of a filled pixel stays zero.
      res_pix <= {{CHAN_W{1'b0}}, quot[2], quot[1], quot[0]};
    end
  end

  // Output register: holds a finished result while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix  <= res_pix;
      out_last <= last_flag;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_blue   = out_pix[0*CHAN_W +: CHAN_W];
  assign results.out_green  = out_pix[1*CHAN_W +: CHAN_W];
  assign results.out_red    = out_pix[2*CHAN_W +: CHAN_W];
  assign results.out_alpha  = out_pix[3*CHAN_W +: CHAN_W];
  assign results.frame_last = out_last;

endmodule

### hdl/acb_checker.sv
// Port checker of the color bleed block and its bind to the top level.
`include "alpha_color_bleed_3x3_assert.svh"

module acb_checker import acb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_blue,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_alpha,
  input logic              frame_last
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `ACB_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid, "result dropped while stalled")

  `ACB_ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable({out_blue, out_green, out_red, out_alpha, frame_last}), "result changed while stalled")

  `ACB_ASSERT_NEXT(a_busy_after_pixel, clk, rst, in_xfer && (in_command == CMD_PIXEL), !in_ready, "pixel transfer did not start the sequencer")

  `ACB_ASSERT_NOW(a_result_latency, clk, rst, $rose(out_valid), !$past(in_xfer) && !$past(in_xfer, 2), "result appeared too soon after a transfer")

endmodule

bind alpha_color_bleed_3x3 acb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .in_command (pixels.command),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_blue   (results.out_blue),
  .out_green  (results.out_green),
  .out_red    (results.out_red),
  .out_alpha  (results.out_alpha),
  .frame_last (results.frame_last)
);

### verif/acb_bleed_checker.sv
// Checker: snoops the pixel, result and register ports, predicts and compares every result.
`timescale 1ns / 100ps

module acb_bleed_checker import acb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  acb_pix_if                    pixels,
  acb_res_if                    results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
    logic              frame_last;
  } bled_pixel_t;

  acb_cfg_t         cfg;
  logic [PIX_W-1:0] line_above [MAX_WIDTH];
  logic [PIX_W-1:0] line_mid   [MAX_WIDTH];
  logic [PIX_W-1:0] win        [NWIN];
  int               col_in, row_in, col_out, row_out;
  bled_pixel_t      due_pixels [$];

  function automatic int eff_size(logic [DIM_W-1:0] v, int max_v);
    if (v == 0) return 1;
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  // Average the opaque in-image neighbours into a transparent center inside the grown crop.
  function automatic logic [PIX_W-1:0] fill_color(int orow, int ocol, int w, int h);
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] n;
    int pl, pt, pr, pb, nr, nc;
    int bs, gs, rs, cnt;
    c = win[CENTER];
    if (c[31:24] != 0) return c;
    if (cfg.crop_right < cfg.crop_left || cfg.crop_bottom < cfg.crop_top) return c;
    pl = int'(cfg.crop_left) - 1;
    if (pl < 0) pl = 0;
    pt = int'(cfg.crop_top) - 1;
    if (pt < 0) pt = 0;
    pr = int'(cfg.crop_right) + 1;
    if (pr > w - 1) pr = w - 1;
    pb = int'(cfg.crop_bottom) + 1;
    if (pb > h - 1) pb = h - 1;
    if (ocol < pl || ocol > pr || orow < pt || orow > pb) return c;
    bs = 0; gs = 0; rs = 0; cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = orow + dr;
        nc = ocol + dc;
        if (dr == 0 && dc == 0) continue;
        if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
        n = win[(dr + 1) * 3 + (dc + 1)];
        if (n[31:24] == 0) continue;
        bs += n[7:0];
        gs += n[15:8];
        rs += n[23:16];
        cnt++;
      end
    end
    if (cnt == 0) return c;
    return {8'h00, 8'(rs / cnt), 8'(gs / cnt), 8'(bs / cnt)};
  endfunction

  // Advance line stores, window and positions by one accepted item.
  function automatic void bleed_pixel_in(logic cmd, logic [PIX_W-1:0] pix_in);
    int w, h, ci, in_idx, out_idx;
    logic [PIX_W-1:0] pix, above, mid, res;
    bled_pixel_t o;
    w = eff_size(cfg.image_width, MAX_WIDTH);
    h = eff_size(cfg.image_height, MAX_HEIGHT);
    if (cmd == CMD_FLUSH && row_in == 0 && col_in == 0 && row_out == 0 && col_out == 0)
      return;
    pix = (cmd == CMD_FLUSH) ? '0 : pix_in;
    ci = (col_in < MAX_WIDTH) ? col_in : MAX_WIDTH - 1;
    above = line_above[ci];
    mid = line_mid[ci];
    line_above[ci] = mid;
    line_mid[ci] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = above;
    win[5] = mid;
    win[8] = pix;
    in_idx = row_in * w + col_in;
    out_idx = row_out * w + col_out;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < 'hFFFF) row_in++;
    end
    if (in_idx < out_idx + w + 1) return;
    res = fill_color(row_out, col_out, w, h);
    o.blue = res[7:0];
    o.green = res[15:8];
    o.red = res[23:16];
    o.alpha = res[31:24];
    o.frame_last = (row_out >= h - 1 && col_out >= w - 1);
    due_pixels.push_back(o);
    if (o.frame_last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bled_pixel_t due;
    if (rst) begin
      cfg.image_width = RST_IMAGE_WIDTH;
      cfg.image_height = RST_IMAGE_HEIGHT;
      cfg.crop_left = RST_CROP_LEFT;
      cfg.crop_top = RST_CROP_TOP;
      cfg.crop_right = RST_CROP_RIGHT;
      cfg.crop_bottom = RST_CROP_BOTTOM;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_above[i] = '0;
        line_mid[i] = '0;
      end
      for (int i = 0; i < NWIN; i++) win[i] = '0;
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      due_pixels.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_IMAGE_WIDTH:  cfg.image_width = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: cfg.image_height = pwdata[DIM_W-1:0];
          REG_CROP_LEFT:    cfg.crop_left = pwdata[CROP_W-1:0];
          REG_CROP_TOP:     cfg.crop_top = pwdata[CROP_W-1:0];
          REG_CROP_RIGHT:   cfg.crop_right = pwdata[CROP_W-1:0];
          REG_CROP_BOTTOM:  cfg.crop_bottom = pwdata[CROP_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (due_pixels.size() == 0) begin
          report("result with nothing due", 1, 0);
        end else begin
          due = due_pixels.pop_front();
          if (results.out_blue !== due.blue) report("out_blue", results.out_blue, due.blue);
          if (results.out_green !== due.green)
            report("out_green", results.out_green, due.green);
          if (results.out_red !== due.red) report("out_red", results.out_red, due.red);
          if (results.out_alpha !== due.alpha)
            report("out_alpha", results.out_alpha, due.alpha);
          if (results.frame_last !== due.frame_last)
            report("frame_last", results.frame_last, due.frame_last);
        end
      end
      if (pixels.valid && pixels.ready)
        bleed_pixel_in(pixels.command, {pixels.alpha, pixels.red, pixels.green, pixels.blue});
      pending <= due_pixels.size();
    end
  end

endmodule

### verif/tb_alpha_color_bleed_3x3.sv
// Testbench top: clock, reset, register writes, pixel stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_alpha_color_bleed_3x3;
  import acb_pkg::*;

  // Allow the longest item (averaged result) to finish before a register write.
  localparam int SETTLE_CYCLES = 40;
  // Leave ample headroom over the slowest legal run.
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int RANDOM_PIXELS = 1500;

  // Stall patterns of the result receiver.
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int pending;
  int cycles = 0;
  int frames_done = 0;
  int burst_left = 0;
  int pixels_sent = 0;
  bit steady = 1'b0;

  rx_pattern_e rx_pattern = RX_OPEN;
  int          rx_left = 0;
  int          rx_phase = 0;

  acb_pix_if pix_if ();
  acb_res_if res_if ();

  alpha_color_bleed_3x3 u_top (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  acb_bleed_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold every block input at a known value before the first edge.
  initial begin
    pix_if.valid = 1'b0;
    pix_if.command = CMD_PIXEL;
    pix_if.blue = '0;
    pix_if.green = '0;
    pix_if.red = '0;
    pix_if.alpha = '0;
    res_if.ready = 1'b0;
  end

  // Receiver: switch between open, coin-flip, periodic and sparse ready patterns
  // in stretches of random length, so stalls land on every phase of the block.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(RX_OPEN, RX_SPARSE));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN:     res_if.ready <= 1'b1;
      RX_COIN:     res_if.ready <= $urandom_range(0, 1);
      RX_PERIODIC: res_if.ready <= (rx_phase % 7) < 4;
      RX_SPARSE:   res_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Count completed frames; a frame is done at the transfer marked frame_last.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready && res_if.frame_last)
      frames_done <= frames_done + 1;
  end

  // Watchdog: fail the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random channel value, biased toward the extremes.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Random crop coordinate: mostly near the image, sometimes at the field extremes.
  function automatic int crop_pick(int span);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1023;
      2:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, span + 1);
    endcase
  endfunction

  // Offer one item and hold it until the transfer. Open a gap between bursts
  // unless the sender runs steady.
  task automatic push_item(logic cmd, logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                           logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
      if (!steady && gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.command <= cmd;
    pix_if.blue <= b;
    pix_if.green <= g;
    pix_if.red <= r;
    pix_if.alpha <= a;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // Send a random pixel; roughly two in five are fully transparent.
  task automatic push_random_pixel();
    logic [CHAN_W-1:0] a;
    a = ($urandom_range(0, 4) < 2) ? '0 : rand_chan();
    push_item(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan(), a);
    pixels_sent++;
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic wait_results();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Drain results, then let a dropped item finish inside the block.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then idle.
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int l, int t, int r, int b);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_CROP_LEFT, l);
    reg_write(REG_CROP_TOP, t);
    reg_write(REG_CROP_RIGHT, r);
    reg_write(REG_CROP_BOTTOM, b);
  endtask

  // Push flushes until the frame_last transfer shows up. Flushes that slip in
  // after the frame end are dropped by the block, which is harmless.
  task automatic finish_frame();
    int start;
    start = frames_done;
    while (frames_done == start) begin
      if (pending == 0) begin
        push_item(CMD_FLUSH, rand_chan(), rand_chan(), rand_chan(), rand_chan());
      end else begin
        pix_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // One whole frame: registers, the pixels, up to a row of extra data pixels
  // past the end, a few mid-frame flushes and pauses, then drain and settle.
  task automatic run_frame(int w_reg, int h_reg, int l, int t, int r, int b);
    int w, h, extra;
    set_frame(w_reg, h_reg, l, t, r, b);
    w = (w_reg % 2048 == 0) ? 1 : ((w_reg % 2048 > 1024) ? 1024 : w_reg % 2048);
    h = (h_reg % 2048 == 0) ? 1 : ((h_reg % 2048 > 1024) ? 1024 : h_reg % 2048);
    extra = $urandom_range(0, w);
    for (int i = 0; i < w * h + extra; i++) begin
      // Never lead with a flush: it would be dropped and shift the frame.
      if (i > 0 && $urandom_range(0, 19) == 0) begin
        push_item(CMD_FLUSH, rand_chan(), rand_chan(), rand_chan(), rand_chan());
        pixels_sent++;
      end else begin
        push_random_pixel();
      end
      if ($urandom_range(0, 99) == 0) wait_results();
    end
    finish_frame();
    settle();
  endtask

  initial begin : stimulus
    int w_reg, h_reg, l, t, r, b, tmp;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-width frame with width above the maximum and height zero; this also
    // writes every line store entry, so later geometry never reads an unwritten one.
    run_frame(2047, 0, 0, 0, 1023, 1023);

    // Flush with nothing received: taken and dropped.
    push_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // 3x3 frame, crop on the center pixel so the grown window covers everything.
    // Mix opaque extremes with transparent pixels, then extra data pixels past the end.
    set_frame(3, 3, 1, 1, 1, 1);
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'h01, 8'h02, 8'h03, 8'h80);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'h09, 8'h55, 8'hAA, 8'h00);
    push_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h80, 8'h01);
    push_item(CMD_PIXEL, 8'h07, 8'h07, 8'h07, 8'h00);
    push_item(CMD_PIXEL, 8'hC8, 8'h64, 8'h32, 8'hFF);
    push_item(CMD_PIXEL, 8'h0A, 8'h14, 8'h1E, 8'h00);
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h00);
    finish_frame();
    settle();

    // Horizontally inverted crop, with a flush mid-frame: nothing gets filled.
    set_frame(2, 2, 1, 0, 0, 1);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_item(CMD_FLUSH, 8'h5A, 8'hA5, 8'h5A, 8'hA5);
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_PIXEL, 8'h09, 8'h09, 8'h09, 8'h00);
    finish_frame();
    settle();

    // Vertically inverted crop.
    set_frame(2, 2, 0, 1, 1, 0);
    push_item(CMD_PIXEL, 8'h11, 8'h22, 8'h33, 8'h00);
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_PIXEL, 8'h80, 8'h40, 8'h20, 8'h10);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    finish_frame();
    settle();

    // Width changed mid-frame: the input column wraps against the new width.
    set_frame(4, 2, 0, 0, 1023, 1023);
    repeat (3) push_random_pixel();
    settle();
    reg_write(REG_IMAGE_WIDTH, 3);
    repeat (4) push_random_pixel();
    finish_frame();
    settle();

    // Tall frame: width zero, height above the maximum.
    run_frame(0, 2047, 0, 0, 0, 1023);

    // Random frames, mostly small; some crops at the extremes, some inverted.
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = 0;
        1:       w_reg = $urandom_range(11, 40);
        default: w_reg = $urandom_range(1, 10);
      endcase
      h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      l = crop_pick(w_reg);
      r = crop_pick(w_reg);
      t = crop_pick(h_reg);
      b = crop_pick(h_reg);
      // Keep most rectangles upright so the fill path sees plenty of work.
      if ($urandom_range(0, 9) < 7) begin
        if (r < l) begin
          tmp = l; l = r; r = tmp;
        end
        if (b < t) begin
          tmp = t; t = b; b = tmp;
        end
      end
      steady = ($urandom_range(0, 3) == 0);
      run_frame(w_reg, h_reg, l, t, r, b);
    end
    steady = 1'b0;

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
